// File: sv/rlfx_pkg.sv
package rlfx_pkg;

	localparam int SINE_TABLE_ENTRIES = 256;
	localparam int HUE_SECTOR_STEPS   = 256;

	localparam int COLOR_W    = 8;
	localparam int PERIOD_W   = 24;
	localparam int COUNT_W    = 25;
	localparam int CFG_IDX_W  = 3;
	localparam int DIV_NUM_W  = COUNT_W + 1;
	localparam int DIV_REM_W  = PERIOD_W;
	localparam int DIV_STEP_W = $clog2(DIV_NUM_W + 1);

	localparam int PHASE_W    = $clog2(4 * SINE_TABLE_ENTRIES);
	localparam int QUAD_K_W   = $clog2(SINE_TABLE_ENTRIES);
	localparam int SINE_IDX_W = QUAD_K_W + 1;
	localparam int MUL_W      = SINE_IDX_W + 1;
	localparam int AB_W       = 2 * QUAD_K_W + 1;
	localparam int SINE_Q_W   = 16;
	localparam int SIN_NUM_W  = AB_W + SINE_Q_W + 4;
	localparam int SINE_D        = (2 * SINE_TABLE_ENTRIES) * (2 * SINE_TABLE_ENTRIES);
	localparam int SINE_DEN_BASE = 5 * SINE_D;
	localparam int FULL_Q16      = 65535;
	localparam int FAC_SUM_W     = SINE_Q_W + 1;
	localparam int FAC_NUM_W     = FAC_SUM_W + COLOR_W;
	localparam int FAC_DIVISOR   = 2 * FULL_Q16;

	localparam int HUE_SPAN   = 6 * HUE_SECTOR_STEPS;
	localparam int HUE_W      = $clog2(HUE_SPAN);
	localparam int FRAC_W     = $clog2(HUE_SECTOR_STEPS);
	localparam int HUE_NUM_W  = PERIOD_W + HUE_W;

	localparam logic [1:0] MODE_SOLID = 2'd0;
	localparam logic [1:0] MODE_CYCLE = 2'd1;
	localparam logic [1:0] MODE_FLASH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd5;

	typedef struct packed {
		logic [1:0]          mode;
		logic [COLOR_W-1:0]  red;
		logic [COLOR_W-1:0]  green;
		logic [COLOR_W-1:0]  blue;
		logic [COLOR_W-1:0]  bright;
		logic [PERIOD_W-1:0] period;
	} cfg_t;

	typedef struct packed {
		logic                  start;
		logic [DIV_REM_W-1:0]  rem_init;
		logic [DIV_NUM_W-1:0]  num;
		logic [DIV_REM_W-1:0]  divisor;
		logic [DIV_STEP_W-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
		logic [DIV_REM_W-1:0] rem;
	} div_stat_t;

	typedef struct packed {
		logic               valid;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_HUE_CHK,
		ST_HUE_DIV,
		ST_HUE_MUL,
		ST_FL_MOD,
		ST_FL_PHS,
		ST_FL_AB,
		ST_FL_SIN,
		ST_FL_SWAIT,
		ST_FL_FAC,
		ST_MUL_R,
		ST_MUL_G,
		ST_MUL_B,
		ST_SCL_R,
		ST_SCL_G,
		ST_SCL_B,
		ST_DONE
	} seq_state_t;

endpackage

// File: sv/rlfx_div.sv
module rlfx_div import rlfx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_cmd_t  cmd,
	output div_stat_t stat
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic [DIV_REM_W-1:0]  rem_q;
	logic [DIV_REM_W-1:0]  dvs_q;
	logic [DIV_NUM_W-1:0]  num_q;
	logic [DIV_NUM_W-1:0]  quo_q;
	logic [DIV_REM_W:0]    trial;
	logic [DIV_REM_W:0]    diff;
	logic                  take;

	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign take  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cmd.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= cmd.rem_init;
			num_q <= cmd.num;
			dvs_q <= cmd.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_NUM_W-2:0], take};
		end
	end

	assign stat.done = done_q;
	assign stat.quo  = quo_q;
	assign stat.rem  = rem_q;

endmodule

// File: sv/rlfx_seq.sv
module rlfx_seq import rlfx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COLOR_W-1:0] elapsed_ticks,
	output res_t               res,
	input  logic               res_ready,
	output div_cmd_t           div_cmd,
	input  div_stat_t          div_stat
);

	seq_state_t state_q, state_d;

	logic [COUNT_W-1:0]   tc_q;
	logic [COUNT_W-1:0]   t_q;
	logic [HUE_W-1:0]     h_q;
	logic [PHASE_W-1:0]   p_q;
	logic [AB_W-1:0]      ab_q;
	logic [COLOR_W-1:0]   f_q;
	logic [COLOR_W-1:0]   r_q, g_q, b_q;

	logic                 accept;
	logic [COUNT_W:0]     sum_in;
	logic                 t_over;
	logic [HUE_NUM_W-1:0] hue_num;
	logic [QUAD_K_W-1:0]  quad_k;
	logic [SINE_IDX_W-1:0] sine_idx;
	logic [DIV_REM_W-1:0] sin_den;
	logic [SIN_NUM_W-1:0] sin_num;
	logic [SINE_Q_W-1:0]  mag;
	logic [FAC_SUM_W-1:0] fac_sum;
	logic [FAC_NUM_W-1:0] fac_num;
	logic [MUL_W-1:0]     mul_a, mul_b;
	logic [2*MUL_W-1:0]   mul_p;
	logic [16:0]          rnd_y;
	logic [17:0]          rnd_s;
	logic [COLOR_W-1:0]   m8;
	logic [15:0]          rise_s;
	logic [COLOR_W-1:0]   rise;
	logic [COLOR_W-1:0]   fall;
	logic [HUE_W-FRAC_W-1:0] sector;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign sum_in   = {1'b0, tc_q} + (COUNT_W+1)'(elapsed_ticks);
	assign t_over   = t_q > COUNT_W'(cfg.period);
	assign hue_num  = HUE_NUM_W'(t_q[PERIOD_W-1:0]) * HUE_NUM_W'(HUE_SPAN);

	assign quad_k   = p_q[QUAD_K_W-1:0];
	assign sine_idx = p_q[QUAD_K_W] ? (SINE_IDX_W'(SINE_TABLE_ENTRIES) - SINE_IDX_W'(quad_k))
	                                : SINE_IDX_W'(quad_k);
	assign sin_den  = DIV_REM_W'(SINE_DEN_BASE) - DIV_REM_W'({ab_q, 2'b00});
	assign sin_num  = (SIN_NUM_W'(ab_q) << (SINE_Q_W + 4)) - (SIN_NUM_W'(ab_q) << 4)
	                + SIN_NUM_W'(sin_den >> 1);

	assign mag     = div_stat.quo[SINE_Q_W-1:0];
	assign fac_sum = p_q[PHASE_W-1] ? (FAC_SUM_W'(FULL_Q16) - FAC_SUM_W'(mag))
	                                : (FAC_SUM_W'(FULL_Q16) + FAC_SUM_W'(mag));
	assign fac_num = (FAC_NUM_W'(fac_sum) << COLOR_W) - FAC_NUM_W'(fac_sum)
	               + FAC_NUM_W'(FULL_Q16);

	assign mul_p = mul_a * mul_b;

	// Rounded product of two 8-bit fractions, (a*b + 127) / 255.
	assign rnd_y = 17'(mul_p[15:0]) + 17'd127;
	assign rnd_s = 18'(rnd_y) + 18'(rnd_y >> 8) + 18'd1;
	assign m8    = rnd_s[15:8];

	assign rise_s = mul_p[15:0] + 16'(HUE_SECTOR_STEPS / 2);
	assign rise   = COLOR_W'(rise_s >> FRAC_W);
	assign fall   = cfg.bright - rise;
	assign sector = h_q[HUE_W-1:FRAC_W];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_R: begin
				mul_a = MUL_W'(cfg.red);
				mul_b = MUL_W'(cfg.bright);
			end
			ST_MUL_G: begin
				mul_a = MUL_W'(cfg.green);
				mul_b = MUL_W'(cfg.bright);
			end
			ST_MUL_B: begin
				mul_a = MUL_W'(cfg.blue);
				mul_b = MUL_W'(cfg.bright);
			end
			ST_SCL_R: begin
				mul_a = MUL_W'(r_q);
				mul_b = MUL_W'(f_q);
			end
			ST_SCL_G: begin
				mul_a = MUL_W'(g_q);
				mul_b = MUL_W'(f_q);
			end
			ST_SCL_B: begin
				mul_a = MUL_W'(b_q);
				mul_b = MUL_W'(f_q);
			end
			ST_HUE_MUL: begin
				mul_a = MUL_W'(cfg.bright);
				mul_b = MUL_W'(h_q[FRAC_W-1:0]);
			end
			ST_FL_AB: begin
				mul_a = MUL_W'(sine_idx);
				mul_b = MUL_W'(2 * SINE_TABLE_ENTRIES) - MUL_W'(sine_idx);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d         = state_q;
		div_cmd.start   = 1'b0;
		div_cmd.rem_init = '0;
		div_cmd.num     = '0;
		div_cmd.divisor = cfg.period;
		div_cmd.steps   = '0;
		res.valid       = 1'b0;
		res.red         = r_q;
		res.green       = g_q;
		res.blue        = b_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cfg.mode)
						MODE_CYCLE: begin
							state_d = ST_HUE_CHK;
						end
						MODE_FLASH: begin
							div_cmd.start = 1'b1;
							div_cmd.num   = sum_in;
							div_cmd.steps = DIV_STEP_W'(DIV_NUM_W);
							state_d       = ST_FL_MOD;
						end
						default: begin
							state_d = ST_MUL_R;
						end
					endcase
				end
			end
			ST_HUE_CHK: begin
				if (t_over) begin
					state_d = ST_HUE_MUL;
				end else begin
					div_cmd.start    = 1'b1;
					div_cmd.rem_init = hue_num[HUE_NUM_W-1:HUE_W];
					div_cmd.num      = {hue_num[HUE_W-1:0], (DIV_NUM_W-HUE_W)'(0)};
					div_cmd.steps    = DIV_STEP_W'(HUE_W);
					state_d          = ST_HUE_DIV;
				end
			end
			ST_HUE_DIV: begin
				if (div_stat.done) begin
					state_d = ST_HUE_MUL;
				end
			end
			ST_HUE_MUL: begin
				state_d = ST_DONE;
			end
			ST_FL_MOD: begin
				if (div_stat.done) begin
					div_cmd.start    = 1'b1;
					div_cmd.rem_init = div_stat.rem;
					div_cmd.steps    = DIV_STEP_W'(PHASE_W);
					state_d          = ST_FL_PHS;
				end
			end
			ST_FL_PHS: begin
				if (div_stat.done) begin
					state_d = ST_FL_AB;
				end
			end
			ST_FL_AB: begin
				state_d = ST_FL_SIN;
			end
			ST_FL_SIN: begin
				div_cmd.start    = 1'b1;
				div_cmd.rem_init = DIV_REM_W'(sin_num[SIN_NUM_W-1:SINE_Q_W]);
				div_cmd.num      = {sin_num[SINE_Q_W-1:0], (DIV_NUM_W-SINE_Q_W)'(0)};
				div_cmd.divisor  = sin_den;
				div_cmd.steps    = DIV_STEP_W'(SINE_Q_W);
				state_d          = ST_FL_SWAIT;
			end
			ST_FL_SWAIT: begin
				if (div_stat.done) begin
					div_cmd.start    = 1'b1;
					div_cmd.rem_init = DIV_REM_W'(fac_num[FAC_NUM_W-1:COLOR_W]);
					div_cmd.num      = {fac_num[COLOR_W-1:0], (DIV_NUM_W-COLOR_W)'(0)};
					div_cmd.divisor  = DIV_REM_W'(FAC_DIVISOR);
					div_cmd.steps    = DIV_STEP_W'(COLOR_W);
					state_d          = ST_FL_FAC;
				end
			end
			ST_FL_FAC: begin
				if (div_stat.done) begin
					state_d = ST_MUL_R;
				end
			end
			ST_MUL_R: begin
				state_d = ST_MUL_G;
			end
			ST_MUL_G: begin
				state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				state_d = (cfg.mode == MODE_FLASH) ? ST_SCL_R : ST_DONE;
			end
			ST_SCL_R: begin
				state_d = ST_SCL_G;
			end
			ST_SCL_G: begin
				state_d = ST_SCL_B;
			end
			ST_SCL_B: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_HUE_CHK) begin
				tc_q <= t_over ? '0 : t_q;
			end else if (state_q == ST_FL_MOD && div_stat.done) begin
				tc_q <= COUNT_W'(div_stat.rem);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					t_q <= sum_in[COUNT_W] ? '1 : sum_in[COUNT_W-1:0];
				end
			end
			ST_HUE_CHK: begin
				if (t_over) begin
					h_q <= '0;
				end
			end
			ST_HUE_DIV: begin
				if (div_stat.done) begin
					h_q <= (div_stat.quo >= DIV_NUM_W'(HUE_SPAN)) ? '0
					                                              : div_stat.quo[HUE_W-1:0];
				end
			end
			ST_HUE_MUL: begin
				case (sector)
					3'd0: begin
						r_q <= cfg.bright;
						g_q <= rise;
						b_q <= '0;
					end
					3'd1: begin
						r_q <= fall;
						g_q <= cfg.bright;
						b_q <= '0;
					end
					3'd2: begin
						r_q <= '0;
						g_q <= cfg.bright;
						b_q <= rise;
					end
					3'd3: begin
						r_q <= '0;
						g_q <= fall;
						b_q <= cfg.bright;
					end
					3'd4: begin
						r_q <= rise;
						g_q <= '0;
						b_q <= cfg.bright;
					end
					default: begin
						r_q <= cfg.bright;
						g_q <= '0;
						b_q <= fall;
					end
				endcase
			end
			ST_FL_PHS: begin
				if (div_stat.done) begin
					p_q <= div_stat.quo[PHASE_W-1:0];
				end
			end
			ST_FL_AB: begin
				ab_q <= mul_p[AB_W-1:0];
			end
			ST_FL_FAC: begin
				if (div_stat.done) begin
					f_q <= div_stat.quo[COLOR_W-1:0];
				end
			end
			ST_MUL_R, ST_SCL_R: begin
				r_q <= m8;
			end
			ST_MUL_G, ST_SCL_G: begin
				g_q <= m8;
			end
			ST_MUL_B, ST_SCL_B: begin
				b_q <= m8;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: sv/rgb_led_effect_generator.sv
// Channel  Handshake               Payload
// in       in_valid / in_ready     elapsed_ticks
// out      out_valid / out_ready   red, green, blue
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each accepted input beat is worked through before the next is taken. Solid mode uses the shared
// multiplier; hue cycle mode adds the shared radix-2 divider, skipped once the count runs past the
// period; flash mode adds divider steps (period remainder, phase, sine entry, flash factor).
// Reset is asynchronous and active low; it restores the register defaults and clears the
// time counter. A stalled output holds its beat; the next input beat is still taken, and its
// result then waits in the sequencer, with the input not ready, until the output register frees.
module rgb_led_effect_generator import rlfx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [COLOR_W-1:0]   elapsed_ticks,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COLOR_W-1:0]   red,
	output logic [COLOR_W-1:0]   green,
	output logic [COLOR_W-1:0]   blue,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data
);

	logic [1:0]          mode_q;
	logic [COLOR_W-1:0]  red_cfg_q;
	logic [COLOR_W-1:0]  green_cfg_q;
	logic [COLOR_W-1:0]  blue_cfg_q;
	logic [COLOR_W-1:0]  bright_q;
	logic [PERIOD_W-1:0] period_q;
	logic                out_valid_q;
	logic [COLOR_W-1:0]  red_q, green_q, blue_q;

	cfg_t      cfg;
	res_t      res;
	logic      res_ready;
	div_cmd_t  div_cmd;
	div_stat_t div_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SOLID;
			red_cfg_q   <= 8'd255;
			green_cfg_q <= 8'd255;
			blue_cfg_q  <= 8'd255;
			bright_q    <= 8'd255;
			period_q    <= 24'd1000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:   mode_q      <= cfg_data[1:0];
				CFG_RED:    red_cfg_q   <= cfg_data[COLOR_W-1:0];
				CFG_GREEN:  green_cfg_q <= cfg_data[COLOR_W-1:0];
				CFG_BLUE:   blue_cfg_q  <= cfg_data[COLOR_W-1:0];
				CFG_BRIGHT: bright_q    <= cfg_data[COLOR_W-1:0];
				CFG_PERIOD: period_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A zero period behaves as a period of one tick.
	assign cfg.mode   = mode_q;
	assign cfg.red    = red_cfg_q;
	assign cfg.green  = green_cfg_q;
	assign cfg.blue   = blue_cfg_q;
	assign cfg.bright = bright_q;
	assign cfg.period = (period_q == '0) ? PERIOD_W'(1) : period_q;

	rlfx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.stat   (div_stat)
	);

	rlfx_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.elapsed_ticks (elapsed_ticks),
		.res           (res),
		.res_ready     (res_ready),
		.div_cmd       (div_cmd),
		.div_stat      (div_stat)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			red_q   <= res.red;
			green_q <= res.green;
			blue_q  <= res.blue;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

endmodule

// File: sv/rlfx_chk.sv
module rlfx_chk import rlfx_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [COLOR_W-1:0]   red,
	input logic [COLOR_W-1:0]   green,
	input logic [COLOR_W-1:0]   blue
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Beats taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
		else $error("output beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input taken again right after a beat");

	a_no_spurious_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("output beat without a pending input beat");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two beats in flight");

endmodule

bind rgb_led_effect_generator rlfx_chk u_rlfx_chk (.*);

// File: tb/rgb_led_effect_generator_checker.sv
module rgb_led_effect_generator_checker import rlfx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [COLOR_W-1:0]   elapsed_ticks,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [COLOR_W-1:0]   red,
	input  logic [COLOR_W-1:0]   green,
	input  logic [COLOR_W-1:0]   blue,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} led_rgb_t;

	localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

	cfg_t               regs;
	logic [COUNT_W-1:0] phase_ticks;
	led_rgb_t           expected_colors[$];
	led_rgb_t           want;
	int                 errs;

	function automatic logic [COLOR_W-1:0] frac_mul(input logic [COLOR_W-1:0] a,
			input logic [COLOR_W-1:0] b);
		int unsigned prod;
		prod = a;
		prod = (prod * b + 127) / 255;
		return prod[COLOR_W-1:0];
	endfunction

	// Quarter-wave sine in Q16, rational approximation over 0..N.
	function automatic longint unsigned sine_q16(input int unsigned idx);
		longint unsigned n2, ab, den;
		n2 = 2 * SINE_TABLE_ENTRIES;
		if (idx > SINE_TABLE_ENTRIES) idx = SINE_TABLE_ENTRIES;
		ab = idx * (n2 - idx);
		den = 5 * n2 * n2 - 4 * ab;
		return (16 * ab * FULL_Q16 + den / 2) / den;
	endfunction

	function automatic led_rgb_t next_color(input logic [COLOR_W-1:0] el);
		longint unsigned per, t, h, p, mag, sum, fac;
		int unsigned     v, frac, rise, fall, q, k;
		led_rgb_t        c;
		per = (regs.period == '0) ? 1 : regs.period;
		case (regs.mode)
		MODE_CYCLE: begin
			t = phase_ticks + el;
			if (t > COUNT_SAT) t = COUNT_SAT;
			if (t > per) begin
				phase_ticks = '0;
				h = 0;
			end else begin
				phase_ticks = t[COUNT_W-1:0];
				h = t * HUE_SPAN / per;
				if (h >= HUE_SPAN) h = 0;
			end
			v = regs.bright;
			frac = 32'(h % HUE_SECTOR_STEPS);
			rise = (v * frac + HUE_SECTOR_STEPS / 2) / HUE_SECTOR_STEPS;
			fall = v - rise;
			case (h / HUE_SECTOR_STEPS)
			0: begin
				c.red = v[7:0]; c.green = rise[7:0]; c.blue = '0;
			end
			1: begin
				c.red = fall[7:0]; c.green = v[7:0]; c.blue = '0;
			end
			2: begin
				c.red = '0; c.green = v[7:0]; c.blue = rise[7:0];
			end
			3: begin
				c.red = '0; c.green = fall[7:0]; c.blue = v[7:0];
			end
			4: begin
				c.red = rise[7:0]; c.green = '0; c.blue = v[7:0];
			end
			default: begin
				c.red = v[7:0]; c.green = '0; c.blue = fall[7:0];
			end
			endcase
		end
		MODE_FLASH: begin
			t = (phase_ticks + el) % per;
			p = t * 4 * SINE_TABLE_ENTRIES / per;
			q = 32'((p / SINE_TABLE_ENTRIES) % 4);
			k = 32'(p % SINE_TABLE_ENTRIES);
			mag = q[0] ? sine_q16(SINE_TABLE_ENTRIES - k) : sine_q16(k);
			sum = q[1] ? FULL_Q16 - mag : FULL_Q16 + mag;
			fac = (sum * 255 + FULL_Q16) / FAC_DIVISOR;
			phase_ticks = t[COUNT_W-1:0];
			c.red   = frac_mul(frac_mul(regs.red, regs.bright), fac[7:0]);
			c.green = frac_mul(frac_mul(regs.green, regs.bright), fac[7:0]);
			c.blue  = frac_mul(frac_mul(regs.blue, regs.bright), fac[7:0]);
		end
		default: begin
			c.red   = frac_mul(regs.red, regs.bright);
			c.green = frac_mul(regs.green, regs.bright);
			c.blue  = frac_mul(regs.blue, regs.bright);
		end
		endcase
		return c;
	endfunction

	task automatic compare_field(input string field, input logic [COLOR_W-1:0] exp_val,
			input logic [COLOR_W-1:0] got_val);
		if (got_val !== exp_val) begin
			errs++;
			$error("%s mismatch: expected %0d, got %0d", field, exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.mode   = MODE_SOLID;
			regs.red    = 8'd255;
			regs.green  = 8'd255;
			regs.blue   = 8'd255;
			regs.bright = 8'd255;
			regs.period = 24'd1000;
			phase_ticks = '0;
			expected_colors.delete();
			errs = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_MODE:   regs.mode   = cfg_data[1:0];
				CFG_RED:    regs.red    = cfg_data[COLOR_W-1:0];
				CFG_GREEN:  regs.green  = cfg_data[COLOR_W-1:0];
				CFG_BLUE:   regs.blue   = cfg_data[COLOR_W-1:0];
				CFG_BRIGHT: regs.bright = cfg_data[COLOR_W-1:0];
				CFG_PERIOD: regs.period = cfg_data;
				default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_colors.size() == 0) begin
					errs++;
					$error("Unexpected result beat: red %0d, green %0d, blue %0d",
						red, green, blue);
				end else begin
					want = expected_colors.pop_front();
					compare_field("red", want.red, red);
					compare_field("green", want.green, green);
					compare_field("blue", want.blue, blue);
				end
			end
			if (in_valid && in_ready)
				expected_colors.push_back(next_color(elapsed_ticks));
			mismatches <= errs;
			outstanding <= expected_colors.size();
		end
	end

endmodule

// File: tb/rgb_led_effect_generator_tb.sv
module rgb_led_effect_generator_tb;
	import rlfx_pkg::*;

	localparam logic [1:0]           MODE_UNUSED   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B   = 3'd7;
	localparam int                   STALL_LIMIT   = 4000;
	localparam int                   SETTLE_CYCLES = 100;
	localparam int                   PHASES        = 12;
	localparam int                   PHASE_BEATS   = 50;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [COLOR_W-1:0]   elapsed_ticks = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [COLOR_W-1:0]   red;
	logic [COLOR_W-1:0]   green;
	logic [COLOR_W-1:0]   blue;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PERIOD_W-1:0]  cfg_data = '0;
	logic                 idling = 1'b1;
	int                   mismatches;
	int                   outstanding;
	int                   stall_cycles = 0;
	int                   beats_sent = 0;
	int                   cfg_writes = 0;

	rgb_led_effect_generator DUT (.*);

	rgb_led_effect_generator_checker checker_i (.*);

	always #2 clk = ~clk;

	always @(posedge clk)
		out_ready <= idling ? ($urandom_range(99) >= 25) : 1'b1;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [PERIOD_W-1:0] rand_word();
		logic [31:0] r;
		r = $urandom;
		return r[PERIOD_W-1:0];
	endfunction

	function automatic logic [COLOR_W-1:0] rand_level();
		int unsigned r;
		r = $urandom_range(7);
		if (r == 0) return '0;
		if (r == 1) return '1;
		r = $urandom_range(255);
		return r[COLOR_W-1:0];
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] data);
		while (idling && $urandom_range(99) < 25) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
	endtask

	task automatic send_ticks(input logic [COLOR_W-1:0] el);
		while (idling && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		elapsed_ticks <= el;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Upper bits of the narrow registers carry junk to check that they are dropped.
	task automatic random_settings();
		logic [1:0]          mode;
		logic [PERIOD_W-1:0] data;
		int unsigned         pick;
		pick = $urandom_range(9);
		mode = (pick < 1) ? MODE_SOLID : (pick < 2) ? MODE_UNUSED :
			(pick < 6) ? MODE_CYCLE : MODE_FLASH;
		data = rand_word();
		data[1:0] = mode;
		write_reg(CFG_MODE, data);
		data = rand_word();
		data[COLOR_W-1:0] = rand_level();
		write_reg(CFG_RED, data);
		data = rand_word();
		data[COLOR_W-1:0] = rand_level();
		write_reg(CFG_GREEN, data);
		data = rand_word();
		data[COLOR_W-1:0] = rand_level();
		write_reg(CFG_BLUE, data);
		data = rand_word();
		data[COLOR_W-1:0] = rand_level();
		write_reg(CFG_BRIGHT, data);
		pick = $urandom_range(9);
		if (pick < 6) pick = $urandom_range(4000, 256);
		else if (pick < 8) pick = $urandom_range(65535, 256);
		else if (pick == 8) pick = rand_word();
		else pick = $urandom_range(255);
		write_reg(CFG_PERIOD, pick[PERIOD_W-1:0]);
		if ($urandom_range(4) == 0)
			write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, rand_word());
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Power-up settings: full white in solid mode.
		send_ticks(8'd0);
		send_ticks(8'd255);
		drain();
		write_reg(CFG_RED, 24'h000000);
		write_reg(CFG_GREEN, 24'hABCD80);
		write_reg(CFG_BLUE, 24'h0000FF);
		cfg_valid <= 1'b0;
		send_ticks(8'h5A);
		drain();
		write_reg(CFG_BRIGHT, 24'h000000);
		cfg_valid <= 1'b0;
		send_ticks(8'hA5);
		drain();
		write_reg(CFG_BRIGHT, 24'h0000FF);
		write_reg(CFG_MODE, {22'h3FFFFD, MODE_UNUSED});
		write_reg(CFG_SPARE_A, 24'hFFFFFF);
		write_reg(CFG_SPARE_B, 24'h5A5A5A);
		cfg_valid <= 1'b0;
		send_ticks(8'h33);

		// Hue sweep up to the period, then one tick past it.
		drain();
		write_reg(CFG_MODE, {22'd0, MODE_CYCLE});
		write_reg(CFG_PERIOD, 24'd1000);
		cfg_valid <= 1'b0;
		send_ticks(8'd255);
		send_ticks(8'd255);
		send_ticks(8'd255);
		send_ticks(8'd235);
		send_ticks(8'd1);
		send_ticks(8'd0);

		// Flash at a period of 256 ticks, one beat per quadrant.
		drain();
		write_reg(CFG_MODE, {22'd0, MODE_FLASH});
		write_reg(CFG_RED, 24'h0000FF);
		write_reg(CFG_GREEN, 24'h0000FF);
		write_reg(CFG_PERIOD, 24'd256);
		cfg_valid <= 1'b0;
		send_ticks(8'd0);
		send_ticks(8'd64);
		send_ticks(8'd64);
		send_ticks(8'd64);
		send_ticks(8'd64);
		drain();
		write_reg(CFG_PERIOD, 24'd0);
		cfg_valid <= 1'b0;
		send_ticks(8'd7);
		drain();
		write_reg(CFG_PERIOD, 24'd1);
		cfg_valid <= 1'b0;
		send_ticks(8'd200);
		drain();
		write_reg(CFG_MODE, {22'd0, MODE_CYCLE});
		write_reg(CFG_PERIOD, 24'hFFFFFF);
		cfg_valid <= 1'b0;
		send_ticks(8'd255);
		send_ticks(8'd255);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			idling <= (ph != 3);
			random_settings();
			for (int i = 0; i < PHASE_BEATS; i++) begin
				if ((ph == 0 && i == PHASE_BEATS / 2) || $urandom_range(59) == 0)
					drain();
				pick = $urandom_range(9);
				if (pick == 0) send_ticks(8'd0);
				else if (pick == 1) send_ticks(8'd255);
				else send_ticks(rand_level());
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d tick beats and %0d register writes over %0d random setting phases.",
			beats_sent, cfg_writes, PHASES);
		$display("Covered solid, hue cycle, flash and the unused mode code, period extremes.");
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
sv/rlfx_pkg.sv
sv/rlfx_div.sv
sv/rlfx_seq.sv
sv/rgb_led_effect_generator.sv
sv/rlfx_chk.sv
tb/rgb_led_effect_generator_checker.sv
tb/rgb_led_effect_generator_tb.sv
